[rtl/bmci_pkg.sv]
// Package for the PRG bank mapper with cycle IRQ.
// It holds the opcodes, register addresses, bank constants and the result type.
// It depends on nothing.
package bmci_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [15:0] ADDR_BANK_SEL = 16'h4022;
  localparam logic [15:0] ADDR_IRQ_LO   = 16'h4122;
  localparam logic [15:0] ADDR_IRQ_HI   = 16'h8122;

  localparam logic [3:0] BANK_6000 = 4'd2;
  localparam logic [3:0] BANK_8000 = 4'd1;
  localparam logic [3:0] BANK_A000 = 4'd0;
  localparam logic [3:0] BANK_E000 = 4'd9;

  localparam int IRQ_BIT      = 12;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;
  localparam int ROM_ADDR_W   = 17;

  typedef struct packed {
    logic                  irq_asserted;
    logic                  rom_hit;
    logic [ROM_ADDR_W-1:0] rom_address;
  } result_t;

  // Bank used by the $C000 window for each bank select value.
  function automatic logic [3:0] c000_bank(input logic [2:0] sel);
    logic [3:0] bank;
    unique case (sel)
      3'd0: bank = 4'd4;
      3'd1: bank = 4'd3;
      3'd2: bank = 4'd4;
      3'd3: bank = 4'd4;
      3'd4: bank = 4'd4;
      3'd5: bank = 4'd7;
      3'd6: bank = 4'd5;
      3'd7: bank = 4'd6;
      default: bank = 4'd4;
    endcase
    return bank;
  endfunction

endpackage

[rtl/bank_mapper_with_cycle_irq.sv]
// Top level of the PRG bank mapper with a cycle-counting IRQ.
// It depends on bmci_pkg for opcodes, addresses, the bank table and the result type.

// The block takes one CPU event per transaction on the input stream (a cycle
// tick, a bus read or a bus write) and returns exactly one result transaction
// for each: the PRG ROM byte address of a read in $5000-$FFFF with a hit flag,
// and the IRQ line as it stands after the event. The translation and the state
// update are a short decode between the input ports and a result register, so
// a new transaction is accepted in every cycle while tready is high. A two-entry
// output stage (result register plus skid register) lets the input side accept
// one more transaction after the output side stalls; tready falls only once
// both entries hold results. The dip_select register is written through its own
// channel, which is always ready, and must only be written while no transaction
// is in flight. Writes to $4122/$8122 change the IRQ enable and may clear the
// counter, but the IRQ line itself is recomputed only on the next tick.
module bank_mapper_with_cycle_irq (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: cpu_address[15:0], write_data[23:16].
  input  logic [bmci_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [1:0]                         s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: rom_address[16:0], irq_asserted[17], zero fill [23:18].
  output logic [bmci_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser from bit 0: rom_hit[0].
  output logic                               m_axis_tuser,
  // Configuration write channel for dip_select.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_data
);
  import bmci_pkg::*;

  // Mapper state.
  logic [1:0]  dip_select;
  logic [2:0]  bank_select;
  logic        irq_enable;
  logic [15:0] cycle_counter;
  logic        irq_line;

  logic [2:0]  bank_select_next;
  logic        irq_enable_next;
  logic [15:0] cycle_counter_next;
  logic        irq_line_next;

  // Output stage: the result register and the skid register behind it.
  logic    out_valid;
  result_t out_result;
  logic    skid_valid;
  result_t skid_result;

  result_t res;
  logic    in_accept;
  logic    out_free;

  logic [1:0]  opcode;
  logic [15:0] cpu_address;
  logic [7:0]  write_data;
  logic [3:0]  bank;

  assign opcode      = s_axis_tuser;
  assign cpu_address = s_axis_tdata[15:0];
  assign write_data  = s_axis_tdata[23:16];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  // The result register can be loaded when it is empty or being drained.
  assign out_free      = !out_valid || m_axis_tready;

  // Read translation: a 4 KB window at $5000 and five 8 KB windows above it.
  always_comb begin
    bank            = BANK_A000;
    res.rom_hit     = 1'b0;
    res.rom_address = '0;
    if (opcode == OP_READ) begin
      unique case (cpu_address[15:12])
        4'h5: begin
          // dip_select lands on ROM bits 11-12, so its low bit is ORed with
          // address bit 11.
          res.rom_hit     = 1'b1;
          res.rom_address = {1'b1, 3'b000, dip_select[1],
                             dip_select[0] | cpu_address[11], cpu_address[10:0]};
        end
        4'h6, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF: begin
          unique case (cpu_address[15:13])
            3'd3:    bank = BANK_6000;
            3'd4:    bank = BANK_8000;
            3'd5:    bank = BANK_A000;
            3'd6:    bank = c000_bank(bank_select);
            default: bank = BANK_E000;
          endcase
          res.rom_hit     = 1'b1;
          res.rom_address = {bank, cpu_address[12:0]};
        end
        default: begin
          res.rom_hit     = 1'b0;
          res.rom_address = '0;
        end
      endcase
    end
    res.irq_asserted = irq_line_next;
  end

  // State update for the accepted event. Opcode 3 leaves everything alone.
  always_comb begin
    bank_select_next   = bank_select;
    irq_enable_next    = irq_enable;
    cycle_counter_next = cycle_counter;
    irq_line_next      = irq_line;
    if (opcode == OP_TICK) begin
      cycle_counter_next = cycle_counter + 16'd1;
      irq_line_next      = cycle_counter_next[IRQ_BIT] && irq_enable;
    end else if (opcode == OP_WRITE) begin
      if (cpu_address == ADDR_BANK_SEL) begin
        bank_select_next = write_data[2:0];
      end else if (cpu_address == ADDR_IRQ_LO || cpu_address == ADDR_IRQ_HI) begin
        irq_enable_next = write_data[0];
        if (write_data[1]) begin
          cycle_counter_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_select    <= 2'd1;
      bank_select   <= '0;
      irq_enable    <= 1'b0;
      cycle_counter <= '0;
      irq_line      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dip_select <= cfg_data;
      end
      if (in_accept) begin
        bank_select   <= bank_select_next;
        irq_enable    <= irq_enable_next;
        cycle_counter <= cycle_counter_next;
        irq_line      <= irq_line_next;
      end
    end
  end

  // Output stage control. The skid entry is always older than any new
  // result, so it moves into the result register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (in_accept) begin
        out_result <= res;
      end
    end else if (in_accept) begin
      skid_result <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - ROM_ADDR_W - 1){1'b0}},
                          out_result.irq_asserted, out_result.rom_address};
  assign m_axis_tuser  = out_result.rom_hit;

endmodule

[rtl/bmci_checker.sv]
// Port-level checker for the PRG bank mapper with cycle IRQ, and its bind.
// It depends on bmci_pkg for the stream widths.
module bmci_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bmci_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import bmci_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // No result is pending right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A miss carries a zero ROM address.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[ROM_ADDR_W-1:0] == '0)
    else $error("miss with nonzero ROM address");

  // Addresses at or above $10000 come only from the $5000 window or bank 9,
  // which leaves bits 15 and 14 clear.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[ROM_ADDR_W-1] |-> m_axis_tdata[15:14] == 2'b00)
    else $error("ROM address beyond the mapped range");

endmodule

bind bank_mapper_with_cycle_irq bmci_checker u_bmci_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_bank_mapper_with_cycle_irq.sv]
// Self-checking testbench for bank_mapper_with_cycle_irq: it streams CPU events,
// predicts each result with its own model of the mapper and compares in order.
// It depends on bmci_pkg and the bank_mapper_with_cycle_irq RTL.
module tb_bank_mapper_with_cycle_irq;
  import bmci_pkg::*;

  localparam logic [1:0]  OP_IGNORED   = 2'd3;
  localparam logic [1:0]  DIP_RESET    = 2'd1;
  localparam logic [16:0] EXTRA_BASE   = 17'h10000;
  localparam int          IDLE_PCT     = 18;
  localparam int          RANDOM_ITEMS = 1350;
  // The counter phase is a short run of mostly ticks with the IRQ enabled.
  localparam int          SOAK_TICKS   = 300;
  localparam int          TAIL_CYCLES  = 10;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          MAX_PRINTED  = 40;

  // Predicts the mapper and holds the results still owed by the block.
  class mapper_scoreboard;
    logic [1:0]  dip_sel;
    logic [2:0]  bank_sel;
    logic        irq_en;
    logic [15:0] cycles;
    logic        irq_line;
    logic [3:0]  c000_table [8];
    result_t     expected_q[$];
    int          mismatches;
    int          results_seen;

    function new();
      dip_sel      = DIP_RESET;
      bank_sel     = '0;
      irq_en       = 1'b0;
      cycles       = '0;
      irq_line     = 1'b0;
      c000_table   = '{4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd7, 4'd5, 4'd6};
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_dip(input logic [1:0] value);
      dip_sel = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Called once per accepted input transaction, in acceptance order.
    function void note_event(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
      result_t r;
      r = '0;
      case (op)
        OP_TICK: begin
          cycles   = cycles + 16'd1;
          irq_line = cycles[IRQ_BIT] & irq_en;
        end
        OP_READ: begin
          r.rom_hit = 1'b1;
          case (addr[15:12])
            4'h5: r.rom_address = EXTRA_BASE | {4'b0, dip_sel, 11'b0} | {5'b0, addr[11:0]};
            4'h6, 4'h7: r.rom_address = {BANK_6000, addr[12:0]};
            4'h8, 4'h9: r.rom_address = {BANK_8000, addr[12:0]};
            4'hA, 4'hB: r.rom_address = {BANK_A000, addr[12:0]};
            4'hC, 4'hD: r.rom_address = {c000_table[bank_sel], addr[12:0]};
            4'hE, 4'hF: r.rom_address = {BANK_E000, addr[12:0]};
            default: r.rom_hit = 1'b0;
          endcase
        end
        OP_WRITE: begin
          if (addr == ADDR_BANK_SEL) begin
            bank_sel = data[2:0];
          end else if (addr == ADDR_IRQ_LO || addr == ADDR_IRQ_HI) begin
            // The line itself only follows on the next tick.
            irq_en = data[0];
            if (data[1]) begin
              cycles = '0;
            end
          end
        end
        default: ;
      endcase
      r.irq_asserted = irq_line;
      expected_q.push_back(r);
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("result %0d: %s", results_seen, msg);
      end
    endtask

    task check_result(input logic [OUT_DATA_W-1:0] tdata, input logic tuser);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, tdata %h tuser %b", tdata, tuser));
        return;
      end
      want = expected_q.pop_front();
      if (tdata[16:0] !== want.rom_address) begin
        report($sformatf("rom_address %h, expected %h", tdata[16:0], want.rom_address));
      end
      if (tdata[17] !== want.irq_asserted) begin
        report($sformatf("irq_asserted %b, expected %b", tdata[17], want.irq_asserted));
      end
      if (tuser !== want.rom_hit) begin
        report($sformatf("rom_hit %b, expected %b", tuser, want.rom_hit));
      end
      if (tdata[23:18] !== 6'b0) begin
        report($sformatf("fill bits %b, expected zero", tdata[23:18]));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = OP_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_data = '0;

  mapper_scoreboard sb;
  bit               steady = 1'b0;
  int               cycle_count = 0;

  bank_mapper_with_cycle_irq uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bank_mapper_with_cycle_irq] ERROR");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then stall at random outside the steady phases.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offers one event and returns at the edge where it is accepted. Valid stays
  // high on return so that back-to-back events need no extra assignment.
  task automatic send_event(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(op, addr, data);
  endtask

  // Holds the input side until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_dip(input logic [1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_dip(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int          ticks;
    logic [15:0] addr;
    logic [7:0]  data;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part with dip_select at its reset value: every window edge,
    // both ends of the $C000 table, IRQ writes, stray writes and the unused opcode.
    send_event(OP_READ,  16'h0000, 8'hFF);
    send_event(OP_READ,  16'h4FFF, 8'h00);
    send_event(OP_READ,  16'h5000, 8'h00);
    send_event(OP_READ,  16'h5FFF, 8'h00);
    send_event(OP_READ,  16'h6000, 8'h00);
    send_event(OP_READ,  16'h7FFF, 8'h00);
    send_event(OP_READ,  16'h8000, 8'h00);
    send_event(OP_READ,  16'h9FFF, 8'h00);
    send_event(OP_READ,  16'hA000, 8'h00);
    send_event(OP_READ,  16'hBFFF, 8'h00);
    send_event(OP_READ,  16'hC000, 8'h00);
    send_event(OP_READ,  16'hE000, 8'h00);
    send_event(OP_READ,  16'hFFFF, 8'hFF);
    send_event(OP_WRITE, ADDR_BANK_SEL, 8'hFF);
    send_event(OP_READ,  16'hDFFF, 8'h00);
    send_event(OP_WRITE, ADDR_BANK_SEL, 8'h05);
    send_event(OP_READ,  16'hC123, 8'h00);
    send_event(OP_WRITE, ADDR_IRQ_LO, 8'h03);
    send_event(OP_TICK,  16'hFFFF, 8'hFF);
    send_event(OP_WRITE, ADDR_IRQ_HI, 8'h02);
    send_event(OP_WRITE, 16'h4023, 8'hFF);
    send_event(OP_WRITE, 16'h0022, 8'hFF);
    send_event(OP_IGNORED, ADDR_BANK_SEL, 8'hFF);
    send_event(OP_TICK,  16'h0000, 8'h00);
    send_event(OP_WRITE, ADDR_BANK_SEL, 8'h00);
    drain();
    write_dip(2'd3);

    // Random mix of events, with dip_select moved between phases.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 700) begin
        drain();
        write_dip(2'd0);
      end
      if (i == 1050) begin
        drain();
        write_dip(2'd2);
      end
      steady = (i >= 250 && i < 500);
      addr = 16'($urandom_range(0, 16'hFFFF));
      data = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_event(OP_TICK, addr, data);
      end else if (pick < 70) begin
        // A quarter of the reads land on the first or last byte of a 4 KB page.
        if ($urandom_range(0, 3) == 0) begin
          addr = 16'($urandom_range(0, 15) << 12);
          if ($urandom_range(0, 1) == 1) begin
            addr[11:0] = 12'hFFF;
          end
        end
        send_event(OP_READ, addr, data);
      end else if (pick < 92) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          addr = ADDR_BANK_SEL;
        end else if (pick < 55) begin
          addr = ADDR_IRQ_LO;
        end else if (pick < 75) begin
          addr = ADDR_IRQ_HI;
        end else if (pick < 88) begin
          addr = ADDR_BANK_SEL ^ (16'h1 << $urandom_range(0, 15));
        end
        send_event(OP_WRITE, addr, data);
      end else begin
        send_event(OP_IGNORED, addr, data);
      end
    end
    drain();
    write_dip(2'd1);

    // Counter phase: IRQ enabled without a clear, mostly ticks. Now and then
    // the enable drops and returns; the line must hold until the following tick.
    data = 8'($urandom_range(0, 255));
    send_event(OP_WRITE, ADDR_IRQ_LO, {data[7:2], 2'b01});
    ticks = 0;
    while (ticks < SOAK_TICKS) begin
      steady = (ticks >= 100 && ticks < 200);
      addr = 16'($urandom_range(0, 16'hFFFF));
      data = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 999);
      if (pick < 120) begin
        send_event(OP_READ, addr, data);
      end else if (pick >= 990) begin
        send_event(OP_WRITE, ADDR_IRQ_HI, {data[7:2], 2'b00});
        send_event(OP_READ, addr, data);
        send_event(OP_TICK, addr, data);
        send_event(OP_WRITE, ADDR_IRQ_LO, {data[7:2], 2'b01});
        ticks++;
      end else begin
        send_event(OP_TICK, addr, data);
        ticks++;
      end
    end

    drain();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[bank_mapper_with_cycle_irq] OK");
    end else begin
      $display("[bank_mapper_with_cycle_irq] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bmci_pkg.sv
rtl/bank_mapper_with_cycle_irq.sv
rtl/bmci_checker.sv
tb/tb_bank_mapper_with_cycle_irq.sv
